FILE: rtl/srft_pkg.sv
// Shared types and constants of the sound RAM write FIFO transfer unit.
package srft_pkg;

	// Command codes on the input channel; code 3 is ignored.
	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_SET_ADDR = 2'd1,
		CMD_FLUSH    = 2'd2
	} srft_cmd_e;

	// Transfer types with a group pattern; every other code repeats the newest word.
	localparam logic [2:0] XFER_SINGLE = 3'd2;
	localparam logic [2:0] XFER_PAIR   = 3'd3;
	localparam logic [2:0] XFER_QUAD   = 3'd4;
	localparam logic [2:0] XFER_OCTET  = 3'd5;

	// Configuration register index.
	localparam logic REG_TRANSFER_TYPE = 1'b0;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned XFER_W = 3;

	// Command queue between the front and the back.
	localparam int unsigned CQ_DEPTH = 2;
	localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	typedef struct packed {
		srft_cmd_e         op;
		logic [WORD_W-1:0] word;
	} srft_cmd_t;

endpackage

FILE: rtl/srft_if.sv
// Channel interfaces: command beats in, RAM write beats out.
interface srft_cmd_if #(
	parameter int unsigned ADDR_W = 19
);
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [15:0]       word;
	logic [ADDR_W-1:0] start_address;

	modport source (output valid, command, word, start_address, input ready);
	modport sink   (input valid, command, word, start_address, output ready);
endinterface

interface srft_wr_if #(
	parameter int unsigned ADDR_W = 19
);
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] ram_address;
	logic [15:0]       ram_data;
	logic              last;

	modport source (output valid, ram_address, ram_data, last, input ready);
	modport sink   (input valid, ram_address, ram_data, last, output ready);
endinterface

FILE: rtl/srft_front.sv
// Front end: accepts command beats, drops unused codes, queues the rest.
module srft_front #(
	parameter int unsigned ADDR_W = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	srft_cmd_if.sink            cmd,
	output logic                q_valid,
	input  logic                q_ready,
	output srft_pkg::srft_cmd_t q_cmd,
	output logic [ADDR_W-1:0]   q_addr
);
	import srft_pkg::*;

	srft_cmd_t         ent_q  [CQ_DEPTH];
	logic [ADDR_W-1:0] addr_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic keep, enq, deq;

	always_comb begin
		case (cmd.command)
			CMD_PUSH, CMD_SET_ADDR, CMD_FLUSH: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign cmd.ready = (cnt_q != CQ_CNT_W'(CQ_DEPTH));
	assign enq       = cmd.valid && cmd.ready && keep;
	assign q_valid   = (cnt_q != '0);
	assign deq       = q_valid && q_ready;
	assign q_cmd     = ent_q[rd_ptr_q];
	assign q_addr    = addr_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wr_ptr_q]  <= '{op: srft_cmd_e'(cmd.command), word: cmd.word};
			addr_q[wr_ptr_q] <= cmd.start_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			if (deq) rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			if (enq && !deq) cnt_q <= cnt_q + CQ_CNT_W'(1);
			else if (!enq && deq) cnt_q <= cnt_q - CQ_CNT_W'(1);
		end
	end

endmodule

FILE: rtl/srft_back.sv
// Back end: word FIFO, write address and the flush sequencer.
module srft_back #(
	parameter int unsigned FIFO_DEPTH = 32,
	parameter int unsigned ADDR_W     = 19
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  srft_pkg::srft_cmd_t       q_cmd,
	input  logic [ADDR_W-1:0]         q_addr,
	input  logic [srft_pkg::XFER_W-1:0] xfer_type,
	srft_wr_if.source                 wr
);
	import srft_pkg::*;

	localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SUM_W = IDX_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

	logic [WORD_W-1:0] mem [FIFO_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	state_t            state_q;
	logic [IDX_W-1:0]  head_q, sel_q;
	logic [CNT_W-1:0]  count_q, grp_q, rep_q;
	logic              last_grp_q;
	logic [ADDR_W-1:0] waddr_q;
	logic              ovalid_q, olast_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [WORD_W-1:0] odata_q;

	logic [SUM_W-1:0] rd_sum, tail_sum, head_sum;
	logic [IDX_W-1:0] rd_idx, tail_idx, head_nxt;
	logic [CNT_W-1:0] f_grp;
	logic [IDX_W-1:0] f_sel;
	logic             f_go, take, push_ok, out_free, emit;

	// Circular indexes: every sum stays below twice the depth.
	assign rd_sum   = SUM_W'(head_q) + SUM_W'(sel_q);
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign head_sum = SUM_W'(head_q) + SUM_W'(grp_q);
	assign rd_idx   = (rd_sum >= DEPTH_S) ? IDX_W'(rd_sum - DEPTH_S) : IDX_W'(rd_sum);
	assign tail_idx = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
	assign head_nxt = (head_sum >= DEPTH_S) ? IDX_W'(head_sum - DEPTH_S) : IDX_W'(head_sum);

	// Group size and the offset of the kept word for a flush.
	always_comb begin
		case (xfer_type)
			XFER_SINGLE: begin
				f_grp = CNT_W'(1);
				f_sel = '0;
			end
			XFER_PAIR: begin
				f_grp = CNT_W'(2);
				f_sel = '0;
			end
			XFER_QUAD: begin
				f_grp = CNT_W'(4);
				f_sel = '0;
			end
			XFER_OCTET: begin
				f_grp = CNT_W'(8);
				f_sel = IDX_W'(7);
			end
			default: begin
				f_grp = count_q;
				f_sel = IDX_W'(count_q - CNT_W'(1));
			end
		endcase
	end

	assign f_go     = (count_q != '0) && (count_q >= f_grp);
	assign q_ready  = (state_q == ST_IDLE);
	assign take     = q_valid && q_ready;
	assign push_ok  = take && (q_cmd.op == CMD_PUSH) && (count_q != DEPTH_C);
	assign out_free = !ovalid_q || wr.ready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk) begin
		if (push_ok) mem[tail_idx] <= q_cmd.word;
		rdata_q <= mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oaddr_q <= waddr_q;
			odata_q <= rdata_q;
			olast_q <= last_grp_q && (rep_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			sel_q      <= '0;
			count_q    <= '0;
			grp_q      <= '0;
			rep_q      <= '0;
			last_grp_q <= 1'b0;
			waddr_q    <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (wr.ready) ovalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (q_cmd.op)
							CMD_PUSH: begin
								if (push_ok) count_q <= count_q + CNT_W'(1);
							end
							CMD_SET_ADDR: waddr_q <= q_addr;
							CMD_FLUSH: begin
								if (f_go) begin
									grp_q   <= f_grp;
									sel_q   <= f_sel;
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rep_q      <= grp_q;
					last_grp_q <= (count_q - grp_q) < grp_q;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						waddr_q <= waddr_q + ADDR_W'(2);
						rep_q   <= rep_q - CNT_W'(1);
						if (rep_q == CNT_W'(1)) begin
							head_q  <= head_nxt;
							count_q <= count_q - grp_q;
							state_q <= last_grp_q ? ST_IDLE : ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign wr.valid       = ovalid_q;
	assign wr.ram_address = oaddr_q;
	assign wr.ram_data    = odata_q;
	assign wr.last        = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

	a_group_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (grp_q != '0) && (count_q >= grp_q) && (rep_q != '0))
		else $error("group larger than queued words");

	a_last_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_grp_q && (rep_q == CNT_W'(1))) |=> (state_q == ST_IDLE) && olast_q)
		else $error("final write did not end the flush");

endmodule

FILE: rtl/sound_ram_fifo_transfer_unit.sv
// Top level of the sound RAM write FIFO transfer unit.
//
// Channels: cmd takes one command beat (push word, set write address, flush);
// wr gives one sound RAM halfword write beat per write, last marking the
// final write of a flush. Both use valid/ready. The APB port holds
// transfer_type at byte address 0; write it only while the unit is idle.
//
// Sequencing: push and set-address beats pass through a two-entry command
// queue, which the back drains only while idle. A flush writes one group
// at a time: a read state fetches the kept word from the FIFO memory, then
// an emit state writes that word once for each word of the group, waiting
// whenever the receiver stalls. The first write of a flush goes from the
// read state through the emit state into the output register.
//
// Reset clears the queue, the word count, the write address, the transfer
// type and the output valid flag; the word memory is not cleared. When the
// receiver stalls, the write beat holds in the output register, the flush
// sequencer waits, and the command queue fills and then drops cmd.ready.
module sound_ram_fifo_transfer_unit #(
	parameter int unsigned FIFO_DEPTH = 32,
	parameter int unsigned ADDR_BITS  = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	srft_cmd_if.sink    cmd,
	srft_wr_if.source   wr,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srft_pkg::*;

	logic              q_valid, q_ready;
	srft_cmd_t         q_cmd;
	logic [ADDR_BITS-1:0] q_addr;
	logic [XFER_W-1:0] xfer_type_q;
	logic              reg_hit;

	// APB: register index is the word address; writes beyond the list drop.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_TRANSFER_TYPE);
	assign prdata  = reg_hit ? 32'(xfer_type_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_type_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			xfer_type_q <= pwdata[XFER_W-1:0];
		end
	end

	// Front: accept and classify command beats, queue them for the back.
	srft_front #(
		.ADDR_W (ADDR_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd),
		.q_addr  (q_addr)
	);

	// Back: hold the word FIFO and sequence flushes into RAM writes.
	srft_back #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.ADDR_W     (ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.q_addr    (q_addr),
		.xfer_type (xfer_type_q),
		.wr        (wr)
	);

endmodule
